// File: sv/siq_pkg.sv
package siq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] head_value;
    logic                     head_valid;
    logic [COUNT_W-1:0]       entry_count;
    logic [1:0]               status;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic pop;     // shift everything one place toward the head
    logic ins;     // place the value at the reached position
    logic search;  // look for the first later entry not smaller
    logic front;   // value goes in front of the head
  } cell_ctrl_t;

endpackage

// File: sv/siq_cell.sv
module siq_cell (
  input  logic                              clk,
  input  siq_pkg::cell_ctrl_t               ctrl,
  input  logic signed [siq_pkg::WORD_W-1:0] value,
  input  logic                              valid,
  input  logic                              at_end,
  input  logic                              is_tail,
  input  logic                              is_first,
  input  logic signed [siq_pkg::WORD_W-1:0] left_entry,
  input  logic signed [siq_pkg::WORD_W-1:0] right_entry,
  input  logic                              reach_in,
  output logic signed [siq_pkg::WORD_W-1:0] entry,
  output logic signed [siq_pkg::WORD_W-1:0] entry_next,
  output logic                              reach_out,
  output logic                              tail_lt,
  output logic                              head_gt
);
  import siq_pkg::*;

  logic ge;
  logic gt;
  logic mark;

  assign ge = entry >= value;
  assign gt = entry > value;

  // this cell is the insertion point if nothing to its left claimed it
  assign mark      = at_end | (ctrl.search & valid & ge & ~is_first) | (is_first & ctrl.front);
  assign reach_out = reach_in | mark;
  assign tail_lt   = is_tail & ~ge;
  assign head_gt   = is_first & valid & gt;

  always_comb begin
    if (ctrl.pop) begin
      entry_next = right_entry;
    end else if (ctrl.ins && reach_out) begin
      entry_next = reach_in ? left_entry : value;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: sv/sorted_insert_queue.sv
// sorted_insert_queue: bounded list of signed words kept in a chain of cells
// a result is registered and shown in the cycle after its item is accepted
// throughput: one item per cycle while results are taken; every operation is done as its item is accepted
// the input stalls only while a finished result waits to be taken
// reset clears the entry count and the result valid; entry words are not cleared
module sorted_insert_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  siq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output siq_pkg::rsp_t  rsp
);
  import siq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic accept;
  logic full;
  logic empty;
  logic is_add;
  logic is_pop;
  logic front_hit;
  logic tail_hit;
  cell_ctrl_t ctrl;

  // per-cell views; the list always fills cells 0 .. count-1
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] at_end_vec;
  logic [CAPACITY-1:0] tail_vec;
  logic [CAPACITY-1:0] reach;
  logic [CAPACITY-1:0] tail_lt_vec;
  logic [CAPACITY-1:0] head_gt_vec;
  logic signed [WORD_W-1:0] entry      [CAPACITY];
  logic signed [WORD_W-1:0] entry_next [CAPACITY];

  // the result register parts the two sides: a new item is taken
  // whenever the previous result is gone or leaves in this cycle
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  assign is_add = accept && ((req.opcode == OP_APPEND) || (req.opcode == OP_INSERT));
  assign is_pop = accept && (req.opcode == OP_POP);

  // front and tail checks come straight from the end cells; the
  // sorted search is used only when neither of them decides
  assign front_hit = |head_gt_vec;
  assign tail_hit  = |tail_lt_vec;

  always_comb begin
    ctrl.pop    = is_pop && !empty;
    ctrl.ins    = is_add && !full;
    ctrl.front  = (req.opcode == OP_INSERT) && front_hit;
    ctrl.search = (req.opcode == OP_INSERT) && !front_hit && !tail_hit;
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     left_reach;
      logic signed [WORD_W-1:0] left_word;
      logic signed [WORD_W-1:0] right_word;

      assign valid_vec[i] = CNT_W'(i) < count;

      if (i == 0) begin : g_first
        assign at_end_vec[i] = !valid_vec[i];
        assign left_reach    = 1'b0;
        assign left_word     = req.value;
      end else begin : g_rest
        assign at_end_vec[i] = !valid_vec[i] && valid_vec[i-1];
        assign left_reach    = reach[i-1];
        assign left_word     = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign tail_vec[i] = valid_vec[i];
        assign right_word  = entry[i];
      end else begin : g_inner
        assign tail_vec[i] = valid_vec[i] && !valid_vec[i+1];
        assign right_word  = entry[i+1];
      end

      siq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .value       (req.value),
        .valid       (valid_vec[i]),
        .at_end      (at_end_vec[i]),
        .is_tail     (tail_vec[i]),
        .is_first    (i == 0),
        .left_entry  (left_word),
        .right_entry (right_word),
        .reach_in    (left_reach),
        .entry       (entry[i]),
        .entry_next  (entry_next[i]),
        .reach_out   (reach[i]),
        .tail_lt     (tail_lt_vec[i]),
        .head_gt     (head_gt_vec[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.head_value  <= (count_next != '0) ? entry_next[0] : '0;
      rsp.head_valid  <= (count_next != '0);
      rsp.entry_count <= COUNT_W'(count_next);
      if (is_add && full) begin
        rsp.status <= ST_FULL;
      end else if (is_pop && empty) begin
        rsp.status <= ST_EMPTY;
      end else begin
        rsp.status <= ST_DONE;
      end
    end
  end

endmodule

// File: sv/siq_check.sv
module siq_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input siq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input siq_pkg::rsp_t rsp
);
  import siq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.head_valid == (rsp.entry_count != '0))
    else $error("head valid disagrees with count");

  // every accepted item shows a result next cycle; only a remove can hit empty
  a_accept_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid &&
      ((rsp.status != ST_EMPTY) || ($past(req.opcode) == OP_POP)))
    else $error("accepted item gave no proper result");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.entry_count == COUNT_W'(CAPACITY))
    else $error("dropped item while not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> !rsp.head_valid && rsp.head_value == '0)
    else $error("empty remove reports a head");

endmodule

bind sorted_insert_queue siq_check u_siq_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// File: test/siq_checker.sv
module siq_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  siq_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  siq_pkg::rsp_t rsp,
  output int            errors,
  output int            pending,
  output int            items_seen,
  output int            results_seen,
  output int            full_seen,
  output int            empty_seen
);
  import siq_pkg::*;

  logic signed [WORD_W-1:0] list_q[$];
  rsp_t                     expected_rsp_q[$];
  rsp_t                     want;
  rsp_t                     got;

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] ref_val);
    if (errors < 40) begin
      $display("%0t: %s is %0h, should be %0h", $time, what, seen, ref_val);
    end
    errors++;
  endtask

  // slot where a sorted insert lands
  function automatic int insert_slot(input logic signed [WORD_W-1:0] v);
    int   slot;
    int   i;
    logic found;
    slot  = list_q.size();
    found = 1'b0;
    if (list_q.size() == 0) begin
      slot = 0;
    end else if (list_q[0] > v) begin
      slot = 0;
    end else if (list_q[list_q.size() - 1] < v) begin
      slot = list_q.size();
    end else begin
      for (i = 1; i < list_q.size(); i++) begin
        if (!found && list_q[i] >= v) begin
          slot  = i;
          found = 1'b1;
        end
      end
    end
    return slot;
  endfunction

  // applies one item to the list copy and returns the result it causes
  function automatic rsp_t update_list(input req_t r);
    rsp_t o;
    o        = '0;
    o.status = ST_DONE;
    case (r.opcode)
      OP_APPEND, OP_INSERT: begin
        if (list_q.size() >= CAPACITY) begin
          o.status = ST_FULL;
        end else if (r.opcode == OP_APPEND) begin
          list_q.push_back(r.value);
        end else begin
          list_q.insert(insert_slot(r.value), r.value);
        end
      end
      OP_POP: begin
        if (list_q.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          void'(list_q.pop_front());
        end
      end
      default: ;
    endcase
    o.head_valid  = (list_q.size() != 0);
    o.head_value  = o.head_valid ? list_q[0] : '0;
    o.entry_count = COUNT_W'(list_q.size());
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      list_q.delete();
      expected_rsp_q.delete();
      errors       = 0;
      items_seen   = 0;
      results_seen = 0;
      full_seen    = 0;
      empty_seen   = 0;
      pending     <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got = rsp;
        if (expected_rsp_q.size() == 0) begin
          report("result with no item waiting, status", 32'(got.status), 32'(ST_DONE));
        end else begin
          want = expected_rsp_q.pop_front();
          results_seen++;
          if (got.head_value !== want.head_value) begin
            report("head_value", got.head_value, want.head_value);
          end
          if (got.head_valid !== want.head_valid) begin
            report("head_valid", 32'(got.head_valid), 32'(want.head_valid));
          end
          if (got.entry_count !== want.entry_count) begin
            report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
          end
          if (got.status !== want.status) begin
            report("status", 32'(got.status), 32'(want.status));
          end
        end
      end
      if (req_valid && req_ready) begin
        want = update_list(req);
        expected_rsp_q.push_back(want);
        items_seen++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
      end
      pending <= expected_rsp_q.size();
    end
  end

endmodule

// File: test/tb.sv
module tb;
  import siq_pkg::*;

  // opcode value the block treats as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 950;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int errors;
  int pending;
  int items_seen;
  int results_seen;
  int full_seen;
  int empty_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sorted_insert_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // watches both channels, keeps its own list and compares every result
  siq_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .errors       (errors),
    .pending      (pending),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .empty_seen   (empty_seen)
  );

  // offer one item and hold it until the block takes it
  // valid stays high on return so a back-to-back item needs no re-raise
  task automatic send_item(input logic [1:0] op, input logic [31:0] val);
    req_t r;
    r.opcode  = op;
    r.value   = val;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // one stretch of the result-side pattern: always ready, mostly ready,
  // mostly stalled, or toggling every cycle
  task automatic ready_stretch();
    int mode;
    int len;
    int k;
    mode = $urandom_range(0, 3);
    len  = $urandom_range(5, 60);
    for (k = 0; k < len; k++) begin
      case (mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 9) < 7);
        2: rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= k[0];
      endcase
      @(posedge clk);
    end
  endtask

  // result side runs on its own; once it holds off long enough for a
  // result to sit unaccepted while the sender keeps offering, so the
  // input backs up behind it
  initial begin
    rsp_ready = 1'b0;
    repeat (12) ready_stretch();
    rsp_ready <= 1'b0;
    repeat (120) @(posedge clk);
    forever ready_stretch();
  end

  // hard stop in case a handshake never completes
  initial begin
    #3000000;
    $display("sorted_insert_queue: mismatch");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    int k;
    int pick;
    int phase_left;
    logic filling;
    logic [1:0] op;
    logic [31:0] val;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list first, then the ordering corner cases
    send_item(OP_POP, 32'h1234_5678);        // remove on empty list
    send_item(OP_INSERT, 32'd5);             // insert into empty list
    send_item(OP_INSERT, 32'd5);             // single equal entry, lands after it
    send_item(OP_INSERT, 32'h8000_0000);     // below head, goes in front
    send_item(OP_INSERT, 32'h7fff_ffff);     // above tail, goes at the end
    send_item(OP_INSERT, 32'd0);             // somewhere in the middle
    send_item(OP_UNUSED, 32'hffff_ffff);     // no-op, reports current list
    send_item(OP_APPEND, 32'h8000_0000);     // list no longer sorted at tail
    send_item(OP_INSERT, 32'hffff_ffff);     // above the unsorted tail, goes at the end
    send_item(OP_INSERT, 32'd5);             // above the new tail, goes at the end
    // fill to capacity with alternating bit patterns
    for (k = 0; k < 8; k++) begin
      send_item(OP_APPEND, k[0] ? 32'haaaa_aaaa : 32'h5555_5555);
    end
    send_item(OP_APPEND, 32'd1);             // dropped, list full
    send_item(OP_INSERT, 32'd1);             // dropped, list full
    send_item(OP_POP, 32'h0);
    send_item(OP_INSERT, 32'h8000_0000);     // below head, fills the slot
    send_item(OP_INSERT, 32'h7fff_ffff);     // full again
    send_item(OP_POP, 32'hffff_ffff);
    send_item(OP_POP, 32'h0);

    // random part: alternate filling and draining phases so the list
    // keeps crossing empty and full; values mix small numbers, which
    // hit equal entries often, full-range words and the two extremes
    sent       = 0;
    filling    = 1'b1;
    phase_left = $urandom_range(30, 60);
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          op = OP_UNUSED;
        end else if (filling) begin
          op = (pick < 48) ? OP_INSERT : (pick < 70) ? OP_APPEND : OP_POP;
        end else begin
          op = (pick < 25) ? OP_INSERT : (pick < 35) ? OP_APPEND : OP_POP;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          val = 32'($urandom_range(0, 16)) - 32'd8;
        end else if (pick < 8) begin
          val = $urandom;
        end else if (pick == 8) begin
          val = 32'h8000_0000 + 32'($urandom_range(0, 3));
        end else begin
          val = 32'h7fff_ffff - 32'($urandom_range(0, 3));
        end
        send_item(op, val);
        sent++;
        phase_left--;
        if (phase_left <= 0) begin
          filling    = !filling;
          phase_left = $urandom_range(30, 60);
        end
      end
      // gap between bursts, skipped now and then for long unbroken runs
      if ($urandom_range(0, 2) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    // drain: every result must come back, then give stray ones a chance
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("run took %0d items and checked %0d results", items_seen, results_seen);
    $display("%0d items dropped on a full list, %0d removes on an empty list",
             full_seen, empty_seen);
    if (errors == 0 && pending == 0) begin
      $display("sorted_insert_queue: match");
    end else begin
      $display("sorted_insert_queue: mismatch");
    end
    $finish;
  end

endmodule
